### rtl/flight_mode_sequencer_assert.svh
// ---------------------------------------------------------------------------
// Flight mode sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef FLIGHT_MODE_SEQUENCER_ASSERT_SVH
`define FLIGHT_MODE_SEQUENCER_ASSERT_SVH

// Condition holds at every edge out of reset.
`define FMS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fms_pkg.sv
// ---------------------------------------------------------------------------
// fms_pkg
// Types, register indexes and constants of the flight mode sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fms_pkg;

  localparam int ALT_W      = 7;
  localparam int YAW_W      = 10;
  localparam int STEP_W     = 8;
  localparam int YAW_EXT_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_INCR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TD_YAW_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TD_YAW_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TD_ALT      = 3'd6;

  // Register reset values
  localparam logic [ALT_W-1:0]  RST_ALT_STEP    = 7'd5;
  localparam logic [STEP_W-1:0] RST_YAW_INCR    = 8'd15;
  localparam logic [YAW_W-1:0]  RST_WIN_LOW     = -10'sd10;
  localparam logic [YAW_W-1:0]  RST_WIN_HIGH    = 10'sd10;
  localparam logic [YAW_W-1:0]  RST_TD_YAW_LOW  = -10'sd5;
  localparam logic [YAW_W-1:0]  RST_TD_YAW_HIGH = 10'sd5;
  localparam logic [ALT_W-1:0]  RST_TD_ALT      = 7'd5;

  // Yaw target saturation limits, at field width and widened for the step sums
  localparam logic signed [YAW_W-1:0]     YAW_MIN     = -10'sd512;
  localparam logic signed [YAW_W-1:0]     YAW_MAX     = 10'sd511;
  localparam logic signed [YAW_EXT_W-1:0] YAW_EXT_MIN = -12'sd512;
  localparam logic signed [YAW_EXT_W-1:0] YAW_EXT_MAX = 12'sd511;

  typedef enum logic [1:0] {
    MODE_LANDED    = 2'd0,
    MODE_CALIBRATE = 2'd1,
    MODE_FLYING    = 2'd2,
    MODE_LANDING   = 2'd3
  } fms_mode_t;

  typedef enum logic [1:0] {
    DUTY_PID    = 2'd0,
    DUTY_SPINUP = 2'd1,
    DUTY_STATIC = 2'd2
  } fms_duty_t;

  typedef struct packed {
    logic [ALT_W-1:0]  alt_step;
    logic [STEP_W-1:0] yaw_incr;
    logic [YAW_W-1:0]  win_low;
    logic [YAW_W-1:0]  win_high;
    logic [YAW_W-1:0]  td_yaw_low;
    logic [YAW_W-1:0]  td_yaw_high;
    logic [ALT_W-1:0]  td_alt;
  } fms_cfg_t;

  typedef struct packed {
    logic             switch_up;
    logic             yaw_calibrated;
    logic [YAW_W-1:0] current_yaw;
    logic [ALT_W-1:0] current_alt;
  } fms_in_t;

  typedef struct packed {
    fms_mode_t        mode;
    logic             first_flight;
    logic             last_switch;
    logic [ALT_W-1:0] alt_target;
    logic [YAW_W-1:0] yaw_target;
  } fms_state_t;

  typedef struct packed {
    fms_mode_t        mode;
    logic             motors_on;
    fms_duty_t        duty_choice;
    logic             run_pid;
    logic             yaw_clear;
    logic [ALT_W-1:0] target_alt;
    logic [YAW_W-1:0] target_yaw;
  } fms_res_t;

endpackage

### rtl/fms_cfg.sv
// ---------------------------------------------------------------------------
// fms_cfg
// Configuration register file, written one register per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fms_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [fms_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [fms_pkg::CFG_DATA_W-1:0]   wr_data,
  output fms_pkg::fms_cfg_t                cfg
);

  fms_pkg::fms_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alt_step    <= fms_pkg::RST_ALT_STEP;
      cfg_r.yaw_incr    <= fms_pkg::RST_YAW_INCR;
      cfg_r.win_low     <= fms_pkg::RST_WIN_LOW;
      cfg_r.win_high    <= fms_pkg::RST_WIN_HIGH;
      cfg_r.td_yaw_low  <= fms_pkg::RST_TD_YAW_LOW;
      cfg_r.td_yaw_high <= fms_pkg::RST_TD_YAW_HIGH;
      cfg_r.td_alt      <= fms_pkg::RST_TD_ALT;
    end else if (wr_en) begin
      case (wr_index)
        fms_pkg::CFG_ALT_STEP:    cfg_r.alt_step    <= wr_data[fms_pkg::ALT_W-1:0];
        fms_pkg::CFG_YAW_INCR:    cfg_r.yaw_incr    <= wr_data[fms_pkg::STEP_W-1:0];
        fms_pkg::CFG_WIN_LOW:     cfg_r.win_low     <= wr_data[fms_pkg::YAW_W-1:0];
        fms_pkg::CFG_WIN_HIGH:    cfg_r.win_high    <= wr_data[fms_pkg::YAW_W-1:0];
        fms_pkg::CFG_TD_YAW_LOW:  cfg_r.td_yaw_low  <= wr_data[fms_pkg::YAW_W-1:0];
        fms_pkg::CFG_TD_YAW_HIGH: cfg_r.td_yaw_high <= wr_data[fms_pkg::YAW_W-1:0];
        fms_pkg::CFG_TD_ALT:      cfg_r.td_alt      <= wr_data[fms_pkg::ALT_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/fms_core.sv
// ---------------------------------------------------------------------------
// fms_core
// One control tick: mode selection, then the action of the selected mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fms_core (
  input  fms_pkg::fms_cfg_t   cfg,
  input  fms_pkg::fms_in_t    tick,
  input  fms_pkg::fms_state_t state,
  output fms_pkg::fms_state_t state_nxt,
  output fms_pkg::fms_res_t   res
);

  logic signed [fms_pkg::YAW_W-1:0]     yaw;
  logic signed [fms_pkg::YAW_W-1:0]     win_lo;
  logic signed [fms_pkg::YAW_W-1:0]     win_hi;
  logic signed [fms_pkg::YAW_W-1:0]     td_lo;
  logic signed [fms_pkg::YAW_W-1:0]     td_hi;
  logic signed [fms_pkg::YAW_W-1:0]     yaw_tgt;
  logic signed [fms_pkg::YAW_W-1:0]     yaw_tgt1;
  logic signed [fms_pkg::YAW_W-1:0]     yaw_tgt2;
  logic signed [fms_pkg::YAW_EXT_W-1:0] yaw_dn;
  logic signed [fms_pkg::YAW_EXT_W-1:0] yaw_up;
  logic [fms_pkg::ALT_W-1:0]            alt_dec;
  logic                                 in_window;
  logic                                 touchdown;
  logic                                 cal_done;
  fms_pkg::fms_mode_t                   sel_mode;
  logic                                 sel_last;
  logic                                 sel_clear;

  assign yaw     = tick.current_yaw;
  assign win_lo  = cfg.win_low;
  assign win_hi  = cfg.win_high;
  assign td_lo   = cfg.td_yaw_low;
  assign td_hi   = cfg.td_yaw_high;
  assign yaw_tgt = state.yaw_target;

  // Landing arithmetic on the stored targets
  assign in_window = (win_lo <= yaw) && (yaw <= win_hi);
  assign alt_dec   = (state.alt_target > cfg.alt_step) ?
                     state.alt_target - cfg.alt_step : '0;

  // Step down toward the window first; the upward step sees that result
  assign yaw_dn = {{2{yaw_tgt[fms_pkg::YAW_W-1]}}, yaw_tgt} -
                  {{(fms_pkg::YAW_EXT_W-fms_pkg::STEP_W){1'b0}}, cfg.yaw_incr};
  always_comb begin
    yaw_tgt1 = yaw_tgt;
    if ((yaw > win_hi) && (yaw == yaw_tgt)) begin
      if (yaw_dn < fms_pkg::YAW_EXT_MIN) begin
        yaw_tgt1 = fms_pkg::YAW_MIN;
      end else begin
        yaw_tgt1 = yaw_dn[fms_pkg::YAW_W-1:0];
      end
    end
  end

  assign yaw_up = {{2{yaw_tgt1[fms_pkg::YAW_W-1]}}, yaw_tgt1} +
                  {{(fms_pkg::YAW_EXT_W-fms_pkg::STEP_W){1'b0}}, cfg.yaw_incr};
  always_comb begin
    yaw_tgt2 = yaw_tgt1;
    if ((yaw < win_lo) && (yaw == yaw_tgt1)) begin
      if (yaw_up > fms_pkg::YAW_EXT_MAX) begin
        yaw_tgt2 = fms_pkg::YAW_MAX;
      end else begin
        yaw_tgt2 = yaw_up[fms_pkg::YAW_W-1:0];
      end
    end
  end

  assign touchdown = (tick.current_alt <= cfg.td_alt) && (td_lo <= yaw) && (yaw <= td_hi);
  assign cal_done  = tick.yaw_calibrated;

  // Mode selection from the switch edge
  always_comb begin
    sel_mode  = state.mode;
    sel_last  = state.last_switch;
    sel_clear = 1'b0;
    if (state.mode == fms_pkg::MODE_LANDED || state.mode == fms_pkg::MODE_FLYING) begin
      if (state.mode == fms_pkg::MODE_LANDED && tick.switch_up && !state.last_switch) begin
        if (state.first_flight) begin
          sel_mode = fms_pkg::MODE_CALIBRATE;
        end else begin
          sel_mode  = fms_pkg::MODE_FLYING;
          sel_clear = 1'b1;
        end
      end
      if (state.mode == fms_pkg::MODE_FLYING && !tick.switch_up && state.last_switch) begin
        sel_mode = fms_pkg::MODE_LANDING;
      end
      sel_last = tick.switch_up;
    end
  end

  // Next state: action of the selected mode
  always_comb begin
    state_nxt              = state;
    state_nxt.mode         = sel_mode;
    state_nxt.last_switch  = sel_last;
    if (sel_clear) begin
      state_nxt.alt_target = '0;
      state_nxt.yaw_target = '0;
    end
    case (sel_mode)
      fms_pkg::MODE_CALIBRATE: begin
        if (cal_done) begin
          state_nxt.first_flight = 1'b0;
          state_nxt.alt_target   = '0;
          state_nxt.yaw_target   = '0;
          state_nxt.mode         = fms_pkg::MODE_FLYING;
        end
      end
      fms_pkg::MODE_LANDING: begin
        if (in_window && (state.alt_target != '0)) begin
          state_nxt.alt_target = alt_dec;
        end
        state_nxt.yaw_target = yaw_tgt2;
        if (touchdown) begin
          state_nxt.mode = fms_pkg::MODE_LANDED;
        end
      end
      default: begin
        // landed and flying leave the targets alone, but for the clear on take-off from landed
      end
    endcase
  end

  // Outputs of the tick
  always_comb begin
    res.mode        = state_nxt.mode;
    res.target_alt  = state_nxt.alt_target;
    res.target_yaw  = state_nxt.yaw_target;
    res.motors_on   = 1'b1;
    res.duty_choice = fms_pkg::DUTY_PID;
    res.run_pid     = 1'b0;
    res.yaw_clear   = 1'b0;
    case (sel_mode)
      fms_pkg::MODE_LANDED: begin
        res.motors_on = 1'b0;
      end
      fms_pkg::MODE_CALIBRATE: begin
        if (cal_done) begin
          res.yaw_clear   = 1'b1;
          res.duty_choice = fms_pkg::DUTY_STATIC;
        end else begin
          res.duty_choice = fms_pkg::DUTY_SPINUP;
        end
      end
      fms_pkg::MODE_FLYING: begin
        res.run_pid = 1'b1;
      end
      fms_pkg::MODE_LANDING: begin
        res.run_pid = 1'b1;
        if (touchdown) begin
          res.duty_choice = fms_pkg::DUTY_STATIC;
        end
      end
      default: begin
        res.motors_on = 1'b0;
      end
    endcase
  end

endmodule

### rtl/flight_mode_sequencer.sv
// ---------------------------------------------------------------------------
// flight_mode_sequencer
// Helicopter flight mode sequencer: one control tick in, one result beat out.
// ---------------------------------------------------------------------------
//
//   channel  handshake             payload
//   -------  --------------------  ----------------------------------------------
//   in       in_valid / in_stall   switch_up, yaw_calibrated, current_yaw, alt
//   out      out_valid / out_stall mode, motors_on, duty_choice, run_pid,
//                                  yaw_clear, target_alt, target_yaw
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// A tick is captured in the input register, evaluated combinationally by
// fms_core and lands in the result register; one tick is accepted every
// cycle while the result side flows, that is while out_stall is low.
// Mode and targets update as the tick moves into the result register, so
// back-to-back ticks see each other's state without a bubble.
// A stalled result holds the pipe; a tick waiting in the input register
// stalls the input only while the result register is full and stalled.
// Synchronous active-low reset: landed, first flight pending, switch seen
// up, targets zero, registers at their defaults, both stages empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flight_mode_sequencer_assert.svh"

module flight_mode_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_switch_up,
  input  logic                            in_yaw_calibrated,
  input  logic signed [fms_pkg::YAW_W-1:0] in_current_yaw,
  input  logic [fms_pkg::ALT_W-1:0]       in_current_alt,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_mode,
  output logic                            out_motors_on,
  output logic [1:0]                      out_duty_choice,
  output logic                            out_run_pid,
  output logic                            out_yaw_clear,
  output logic [fms_pkg::ALT_W-1:0]       out_target_alt,
  output logic signed [fms_pkg::YAW_W-1:0] out_target_yaw,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fms_pkg::fms_cfg_t   cfg;
  fms_pkg::fms_in_t    tick_r;
  fms_pkg::fms_state_t state_r;
  fms_pkg::fms_state_t state_nxt;
  fms_pkg::fms_res_t   res_nxt;
  fms_pkg::fms_res_t   res_r;
  logic                tick_v_r;
  logic                res_v_r;
  logic                adv;
  logic                in_take;

  // Writes must arrive only while idle (the block does not enforce it); the register file never pushes back
  assign cfg_ready = 1'b1;

  fms_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held tick whenever the result register is empty or draining
  assign adv      = tick_v_r && !(res_v_r && out_stall);
  assign in_stall = tick_v_r && res_v_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Input register: valid cleared by reset, payload captured on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_v_r <= 1'b0;
    end else if (in_take) begin
      tick_v_r <= 1'b1;
    end else if (adv) begin
      tick_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r.switch_up      <= in_switch_up;
      tick_r.yaw_calibrated <= in_yaw_calibrated;
      tick_r.current_yaw    <= in_current_yaw;
      tick_r.current_alt    <= in_current_alt;
    end
  end

  fms_core u_core (
    .cfg       (cfg),
    .tick      (tick_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  // Mode, flags and targets commit as the tick leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode         <= fms_pkg::MODE_LANDED;
      state_r.first_flight <= 1'b1;
      state_r.last_switch  <= 1'b1;
      state_r.alt_target   <= '0;
      state_r.yaw_target   <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register: hold while stalled, drop the beat once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (adv) begin
      res_v_r <= 1'b1;
    end else if (!out_stall) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_v_r;
  assign out_mode        = res_r.mode;
  assign out_motors_on   = res_r.motors_on;
  assign out_duty_choice = res_r.duty_choice;
  assign out_run_pid     = res_r.run_pid;
  assign out_yaw_clear   = res_r.yaw_clear;
  assign out_target_alt  = res_r.target_alt;
  assign out_target_yaw  = res_r.target_yaw;

  // The reported mode is always the mode the sequencer now holds
  `FMS_ASSERT_NEXT(a_mode_tracks_state, adv, res_r.mode == state_r.mode, "result mode differs from held mode")
  // Calibration completes only once: first flight never comes back
  `FMS_ASSERT_NEXT(a_first_flight_sticky, !state_r.first_flight, !state_r.first_flight, "first flight flag set again")
  // A yaw clear pulse comes with the hand-over to flying on static duty
  `FMS_ASSERT_ALWAYS(a_yaw_clear_flying, !(res_v_r && res_r.yaw_clear) || (res_r.mode == fms_pkg::MODE_FLYING && res_r.duty_choice == fms_pkg::DUTY_STATIC), "yaw clear outside calibration hand-over")
  // PID runs only with the motors on
  `FMS_ASSERT_ALWAYS(a_pid_needs_motors, !(res_v_r && res_r.run_pid) || res_r.motors_on, "PID enabled with motors off")

endmodule
